[src/damped_wave_grid_step_unit_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the damped wave grid step unit
// Immediate-implication and next-cycle-implication checks on the system clock.
// ----------------------------------------------------------------------------
`ifndef DAMPED_WAVE_GRID_STEP_UNIT_MACROS_SVH
`define DAMPED_WAVE_GRID_STEP_UNIT_MACROS_SVH

`ifndef NO_ASSERTIONS
// Consequent must hold in the same cycle as the antecedent.
`define DWG_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("dwg assertion failed");
// Consequent must hold in the cycle after the antecedent.
`define DWG_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("dwg assertion failed");
`else
`define DWG_ASSERT_SAME(label, ante, cons)
`define DWG_ASSERT_NEXT(label, ante, cons)
`endif

`endif

[src/dwg_pkg.sv]
// ----------------------------------------------------------------------------
// dwg_pkg
// Shared constants, codes and types of the damped wave grid step unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package dwg_pkg;

    // Grid geometry: cell (row, col) lives at row*MAX_GRID + col.
    localparam int MAX_GRID  = 128;
    localparam int GRID_BITS = $clog2(MAX_GRID);
    localparam int CELLS     = MAX_GRID * MAX_GRID;
    localparam int CELL_BITS = $clog2(CELLS);
    localparam int SIDE_BITS = 8;
    localparam int MIN_GRID  = 3;

    // Arithmetic widths.
    localparam int HEIGHT_BITS = 16;
    localparam int COEF_BITS   = 16;
    localparam int FRAC_BITS   = 14;
    localparam int SUM_BITS    = HEIGHT_BITS + 2;
    localparam int PROD_BITS   = COEF_BITS + SUM_BITS;
    localparam int ACC_BITS    = PROD_BITS + 2;
    localparam int CFG_BITS    = 16;
    localparam int CFG_IDX_BITS = 3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_BITS-1:0] CFG_GRID    = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_COEF_A  = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_COEF_B  = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_COEF_C  = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_HONOUR  = 3'd4;

    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_DROP  = 2'd1,
        OP_STEP  = 2'd2,
        OP_READ  = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        STAT_OK     = 2'd0,
        STAT_RANGE  = 2'd1,
        STAT_BORDER = 2'd2,
        STAT_SAT    = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_OP_RD, S_OP_EXE,
        S_SRD, S_SCTR, S_SUP, S_SDN, S_SLF, S_SRT, S_SMB, S_SMC, S_SACC, S_SWR,
        S_DONE
    } t_state;

    // Control of the shared multiply-accumulate unit.
    typedef struct packed {
        logic mul_en;
        logic acc_load;
        logic acc_add;
    } t_mac_ctl;

endpackage

[src/dwg_ram.sv]
// ----------------------------------------------------------------------------
// dwg_ram
// Simple dual-port RAM: one write port and one registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dwg_ram #(
    parameter int DEPTH      = 16384,
    parameter int WIDTH      = 16,
    parameter int ADDR_BITS  = $clog2(DEPTH)
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [ADDR_BITS-1:0] i_waddr,
    input  logic [WIDTH-1:0]     i_wdata,
    input  logic [ADDR_BITS-1:0] i_raddr,
    output logic [WIDTH-1:0]     o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[src/dwg_mac.sv]
// ----------------------------------------------------------------------------
// dwg_mac
// Shared multiply-accumulate unit with Q2.14 rounding and height saturation.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dwg_mac (
    input  logic                                i_clk,
    input  dwg_pkg::t_mac_ctl                   i_ctl,
    input  logic signed [dwg_pkg::COEF_BITS-1:0] i_coef,
    input  logic signed [dwg_pkg::SUM_BITS-1:0]  i_data,
    output logic signed [dwg_pkg::HEIGHT_BITS-1:0] o_result,
    output logic                                o_sat
);
    import dwg_pkg::*;

    localparam int RND_BITS = ACC_BITS - FRAC_BITS;

    logic signed [PROD_BITS-1:0] r_prod;
    logic signed [ACC_BITS-1:0]  r_acc;
    logic signed [ACC_BITS-1:0]  n_acc;
    logic signed [ACC_BITS-1:0]  biased;
    logic signed [RND_BITS-1:0]  rounded;
    logic signed [RND_BITS-1:0]  h_max;
    logic signed [RND_BITS-1:0]  h_min;

    // The product is registered before it is summed.
    always_ff @(posedge i_clk) begin
        if (i_ctl.mul_en) begin
            r_prod <= i_coef * i_data;
        end
        r_acc <= n_acc;
    end

    // Accumulator load or add.
    always_comb begin
        n_acc = r_acc;
        if (i_ctl.acc_load) begin
            n_acc = ACC_BITS'(r_prod);
        end else if (i_ctl.acc_add) begin
            n_acc = r_acc + ACC_BITS'(r_prod);
        end
    end

    // Round half up by adding half an LSB and flooring, then saturate.
    always_comb begin
        biased  = r_acc + ACC_BITS'(1 <<< (FRAC_BITS - 1));
        rounded = RND_BITS'(biased >>> FRAC_BITS);
        h_max   = RND_BITS'((1 <<< (HEIGHT_BITS - 1)) - 1);
        h_min   = -h_max - RND_BITS'(1);
        o_sat   = 1'b1;
        if (rounded > h_max) begin
            o_result = {1'b0, {(HEIGHT_BITS-1){1'b1}}};
        end else if (rounded < h_min) begin
            o_result = {1'b1, {(HEIGHT_BITS-1){1'b0}}};
        end else begin
            o_result = rounded[HEIGHT_BITS-1:0];
            o_sat    = 1'b0;
        end
    end

endmodule

[src/damped_wave_grid_step_unit.sv]
// ----------------------------------------------------------------------------
// damped_wave_grid_step_unit
// Square grid of Q8.8 water heights with cell access and damped wave steps.
// ----------------------------------------------------------------------------
//  Channel   Direction  tdata (low bit up)                      tuser
//  s_axis    in         row, col, height_value, prev_value,      op
//                       border_value
//  m_axis    out        height_out, prev_out, border_out         status
//  cfg       in         i_cfg_idx selects register, i_cfg_data   -
//
//  Write, drop and read wait out the registered memory read.
//  A time step visits all 16384 cells; an updated cell, unlike one that is
//  set to zero, also reads its four neighbours and uses the one shared multiplier.
//  After reset a clearing pass over all 16384 cells zeroes all memories; no
//  transfer is taken meanwhile. A stalled result holds the next item back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module damped_wave_grid_step_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // row[6:0], col[13:7], height_value[29:14], prev_value[45:30],
    // border_value[46], zero[47]
    input  logic [47:0] s_axis_tdata,
    // op[1:0]
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // height_out[15:0], prev_out[31:16], border_out[32], zero[39:33]
    output logic [39:0] m_axis_tdata,
    // status[1:0]
    output logic [1:0]  m_axis_tuser,
    input  logic        i_cfg_we,
    input  logic [dwg_pkg::CFG_IDX_BITS-1:0] i_cfg_idx,
    input  logic [dwg_pkg::CFG_BITS-1:0]     i_cfg_data
);
    import dwg_pkg::*;

    `include "damped_wave_grid_step_unit_macros.svh"

    typedef logic signed [HEIGHT_BITS-1:0] t_h;

    // Configuration registers.
    logic [SIDE_BITS-1:0]        r_grid;
    logic signed [COEF_BITS-1:0] r_coef_a;
    logic signed [COEF_BITS-1:0] r_coef_b;
    logic signed [COEF_BITS-1:0] r_coef_c;
    logic                        r_honour;

    // Control state.
    t_state r_state, n_state;
    logic [CELL_BITS-1:0] r_idx, n_idx;
    logic r_bank, n_bank;
    logic r_hit, n_hit;
    logic r_out_valid, n_out_valid;

    // Item and working payload.
    t_op  r_op, n_op;
    t_h   r_hv, n_hv, r_pv, n_pv;
    logic r_bv, n_bv;
    t_h   r_center, n_center, r_prev, n_prev;
    logic signed [SUM_BITS-1:0] r_sum, n_sum;
    t_h   r_res_h, n_res_h, r_res_p, n_res_p;
    logic r_res_b, n_res_b;
    t_status r_res_s, n_res_s;
    t_h   r_out_h, n_out_h, r_out_p, n_out_p;
    logic r_out_b, n_out_b;
    t_status r_out_s, n_out_s;

    // Memory ports.
    logic [CELL_BITS-1:0] cur_raddr;
    logic cur_we, prv_we, brd_we;
    t_h   cur_wdata, prv_wdata;
    logic brd_wdata;
    t_h   a_q, b_q, cur_q, prv_q;
    logic brd_q;

    // Shared unit.
    t_mac_ctl mac_ctl;
    logic signed [COEF_BITS-1:0] mac_coef;
    logic signed [SUM_BITS-1:0]  mac_data;
    t_h   mac_result;
    logic mac_sat;

    // Helpers.
    logic [SIDE_BITS-1:0]  side;
    logic [GRID_BITS-1:0]  in_row, in_col, cell_r, cell_c;
    logic                  inner_pos, last_cell;
    logic signed [HEIGHT_BITS:0] drop_sum;
    t_h   drop_sat;

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid   <= SIDE_BITS'(MAX_GRID);
            r_coef_a <= 16'sd24361;
            r_coef_b <= -16'sd16097;
            r_coef_c <= 16'sd2030;
            r_honour <= 1'b1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_GRID:   r_grid   <= i_cfg_data[SIDE_BITS-1:0];
                CFG_COEF_A: r_coef_a <= i_cfg_data;
                CFG_COEF_B: r_coef_b <= i_cfg_data;
                CFG_COEF_C: r_coef_c <= i_cfg_data;
                CFG_HONOUR: r_honour <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Memories: two height banks and the border map.
    dwg_ram #(.DEPTH(CELLS), .WIDTH(HEIGHT_BITS)) u_bank_a (
        .i_clk   (i_clk),
        .i_we    (r_bank ? prv_we : cur_we),
        .i_waddr (r_idx),
        .i_wdata (r_bank ? prv_wdata : cur_wdata),
        .i_raddr (r_bank ? r_idx : cur_raddr),
        .o_rdata (a_q)
    );

    dwg_ram #(.DEPTH(CELLS), .WIDTH(HEIGHT_BITS)) u_bank_b (
        .i_clk   (i_clk),
        .i_we    (r_bank ? cur_we : prv_we),
        .i_waddr (r_idx),
        .i_wdata (r_bank ? cur_wdata : prv_wdata),
        .i_raddr (r_bank ? cur_raddr : r_idx),
        .o_rdata (b_q)
    );

    dwg_ram #(.DEPTH(CELLS), .WIDTH(1)) u_border (
        .i_clk   (i_clk),
        .i_we    (brd_we),
        .i_waddr (r_idx),
        .i_wdata (brd_wdata),
        .i_raddr (r_idx),
        .o_rdata (brd_q)
    );

    assign cur_q = r_bank ? b_q : a_q;
    assign prv_q = r_bank ? a_q : b_q;

    dwg_mac u_mac (
        .i_clk    (i_clk),
        .i_ctl    (mac_ctl),
        .i_coef   (mac_coef),
        .i_data   (mac_data),
        .o_result (mac_result),
        .o_sat    (mac_sat)
    );

    // Grid side clamped to the supported range, and cell position tests.
    always_comb begin
        side = r_grid;
        if (r_grid < SIDE_BITS'(MIN_GRID)) begin
            side = SIDE_BITS'(MIN_GRID);
        end else if (r_grid > SIDE_BITS'(MAX_GRID)) begin
            side = SIDE_BITS'(MAX_GRID);
        end
        in_row    = s_axis_tdata[GRID_BITS-1:0];
        in_col    = s_axis_tdata[2*GRID_BITS-1:GRID_BITS];
        cell_r    = r_idx[CELL_BITS-1:GRID_BITS];
        cell_c    = r_idx[GRID_BITS-1:0];
        inner_pos = (cell_r != '0) && (cell_c != '0)
                 && ((SIDE_BITS'(cell_r) + SIDE_BITS'(1)) < side)
                 && ((SIDE_BITS'(cell_c) + SIDE_BITS'(1)) < side);
        last_cell = (r_idx == CELL_BITS'(CELLS - 1));
        drop_sum  = (HEIGHT_BITS+1)'(cur_q) + (HEIGHT_BITS+1)'(r_hv);
        if (drop_sum[HEIGHT_BITS] != drop_sum[HEIGHT_BITS-1]) begin
            drop_sat = drop_sum[HEIGHT_BITS] ? {1'b1, {(HEIGHT_BITS-1){1'b0}}}
                                             : {1'b0, {(HEIGHT_BITS-1){1'b1}}};
        end else begin
            drop_sat = drop_sum[HEIGHT_BITS-1:0];
        end
    end

    // Neighbour read address of the current bank.
    always_comb begin
        unique case (r_state)
            S_SCTR:  cur_raddr = r_idx - CELL_BITS'(MAX_GRID);
            S_SUP:   cur_raddr = r_idx + CELL_BITS'(MAX_GRID);
            S_SDN:   cur_raddr = r_idx - CELL_BITS'(1);
            S_SLF:   cur_raddr = r_idx + CELL_BITS'(1);
            default: cur_raddr = r_idx;
        endcase
    end

    // State and control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_idx       <= '0;
            r_bank      <= 1'b0;
            r_hit       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_bank      <= n_bank;
            r_hit       <= n_hit;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_op     <= n_op;
        r_hv     <= n_hv;
        r_pv     <= n_pv;
        r_bv     <= n_bv;
        r_center <= n_center;
        r_prev   <= n_prev;
        r_sum    <= n_sum;
        r_res_h  <= n_res_h;
        r_res_p  <= n_res_p;
        r_res_b  <= n_res_b;
        r_res_s  <= n_res_s;
        r_out_h  <= n_out_h;
        r_out_p  <= n_out_p;
        r_out_b  <= n_out_b;
        r_out_s  <= n_out_s;
    end

    // Sequencer: next state, memory writes and shared unit control.
    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_bank      = r_bank;
        n_hit       = r_hit;
        n_out_valid = r_out_valid;
        n_op        = r_op;
        n_hv        = r_hv;
        n_pv        = r_pv;
        n_bv        = r_bv;
        n_center    = r_center;
        n_prev      = r_prev;
        n_sum       = r_sum;
        n_res_h     = r_res_h;
        n_res_p     = r_res_p;
        n_res_b     = r_res_b;
        n_res_s     = r_res_s;
        n_out_h     = r_out_h;
        n_out_p     = r_out_p;
        n_out_b     = r_out_b;
        n_out_s     = r_out_s;
        cur_we      = 1'b0;
        prv_we      = 1'b0;
        brd_we      = 1'b0;
        cur_wdata   = '0;
        prv_wdata   = '0;
        brd_wdata   = 1'b0;
        mac_ctl     = '0;
        mac_coef    = r_coef_a;
        mac_data    = SUM_BITS'(r_center);
        s_axis_tready = (r_state == S_IDLE);

        // The output register empties on a completed transfer.
        if (r_out_valid && m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            // Zero every entry of all three memories after reset.
            S_CLEAR: begin
                cur_we = 1'b1;
                prv_we = 1'b1;
                brd_we = 1'b1;
                n_idx  = r_idx + CELL_BITS'(1);
                if (last_cell) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    n_op  = t_op'(s_axis_tuser);
                    n_hv  = s_axis_tdata[2*GRID_BITS+HEIGHT_BITS-1:2*GRID_BITS];
                    n_pv  = s_axis_tdata[2*GRID_BITS+2*HEIGHT_BITS-1:
                                         2*GRID_BITS+HEIGHT_BITS];
                    n_bv  = s_axis_tdata[2*GRID_BITS+2*HEIGHT_BITS];
                    n_res_h = '0;
                    n_res_p = '0;
                    n_res_b = 1'b0;
                    if (t_op'(s_axis_tuser) == OP_STEP) begin
                        n_idx   = '0;
                        n_hit   = 1'b0;
                        n_state = S_SRD;
                    end else if (SIDE_BITS'(in_row) >= side
                              || SIDE_BITS'(in_col) >= side) begin
                        n_res_s = STAT_RANGE;
                        n_state = S_DONE;
                    end else begin
                        n_idx   = {in_row, in_col};
                        n_state = S_OP_RD;
                    end
                end
            end
            S_OP_RD: n_state = S_OP_EXE;
            // Cell data is back from the memories.
            S_OP_EXE: begin
                n_res_h = cur_q;
                n_res_p = prv_q;
                n_res_b = brd_q;
                n_res_s = STAT_OK;
                unique case (r_op)
                    OP_WRITE: begin
                        cur_we    = 1'b1;
                        prv_we    = 1'b1;
                        brd_we    = 1'b1;
                        cur_wdata = r_hv;
                        prv_wdata = r_pv;
                        brd_wdata = r_bv;
                        n_res_h   = r_hv;
                        n_res_p   = r_pv;
                        n_res_b   = r_bv;
                    end
                    OP_DROP: begin
                        if (brd_q) begin
                            n_res_s = STAT_BORDER;
                        end else begin
                            cur_we    = 1'b1;
                            cur_wdata = drop_sat;
                            n_res_h   = drop_sat;
                        end
                    end
                    default: ;
                endcase
                n_state = S_DONE;
            end
            // Time step: read centre, previous height and border mark.
            S_SRD: n_state = S_SCTR;
            S_SCTR: begin
                n_center = cur_q;
                n_prev   = prv_q;
                if (!inner_pos || (r_honour && brd_q)) begin
                    prv_we = 1'b1;
                    n_idx  = r_idx + CELL_BITS'(1);
                    if (last_cell) begin
                        n_bank  = ~r_bank;
                        n_res_s = r_hit ? STAT_SAT : STAT_OK;
                        n_state = S_DONE;
                    end else begin
                        n_state = S_SRD;
                    end
                end else begin
                    n_state = S_SUP;
                end
            end
            S_SUP: begin
                n_sum   = SUM_BITS'(cur_q);
                n_state = S_SDN;
            end
            S_SDN: begin
                n_sum   = r_sum + SUM_BITS'(cur_q);
                n_state = S_SLF;
            end
            S_SLF: begin
                n_sum   = r_sum + SUM_BITS'(cur_q);
                n_state = S_SRT;
            end
            S_SRT: begin
                n_sum          = r_sum + SUM_BITS'(cur_q);
                mac_ctl.mul_en = 1'b1;
                n_state        = S_SMB;
            end
            S_SMB: begin
                mac_ctl.acc_load = 1'b1;
                mac_ctl.mul_en   = 1'b1;
                mac_coef         = r_coef_b;
                mac_data         = SUM_BITS'(r_prev);
                n_state          = S_SMC;
            end
            S_SMC: begin
                mac_ctl.acc_add = 1'b1;
                mac_ctl.mul_en  = 1'b1;
                mac_coef        = r_coef_c;
                mac_data        = r_sum;
                n_state         = S_SACC;
            end
            S_SACC: begin
                mac_ctl.acc_add = 1'b1;
                n_state         = S_SWR;
            end
            S_SWR: begin
                prv_we    = 1'b1;
                prv_wdata = mac_result;
                n_hit     = r_hit | mac_sat;
                n_idx     = r_idx + CELL_BITS'(1);
                if (last_cell) begin
                    n_bank  = ~r_bank;
                    n_res_s = (r_hit | mac_sat) ? STAT_SAT : STAT_OK;
                    n_state = S_DONE;
                end else begin
                    n_state = S_SRD;
                end
            end
            // Hand the result over once the output register is free.
            S_DONE: begin
                if (!r_out_valid || m_axis_tready) begin
                    n_out_valid = 1'b1;
                    n_out_h     = r_res_h;
                    n_out_p     = r_res_p;
                    n_out_b     = r_res_b;
                    n_out_s     = r_res_s;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {7'd0, r_out_b, r_out_p, r_out_h};
    assign m_axis_tuser  = r_out_s;

    // Checks on the sequencer.
    `DWG_ASSERT_SAME(a_no_take_in_clear, r_state == S_CLEAR, !s_axis_tready)
    `DWG_ASSERT_NEXT(a_step_starts, s_axis_tvalid && s_axis_tready
                     && s_axis_tuser == OP_STEP, r_state == S_SRD)
    `DWG_ASSERT_NEXT(a_bank_only_at_step_end, r_state != S_SWR && r_state != S_SCTR,
                     $stable(r_bank))
    `DWG_ASSERT_SAME(a_step_writes_next_bank, r_state == S_SWR || r_state == S_SCTR,
                     !cur_we && !brd_we)

endmodule
